@@ rtl/rhac_pkg.sv @@
package rhac_pkg;

   localparam int POOL_BYTES  = 65536;
   localparam int MAX_OBJECTS = 64;
   localparam int IDX_W       = $clog2(MAX_OBJECTS);
   localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

   localparam logic [1:0] KIND_INSERT   = 2'd0;
   localparam logic [1:0] KIND_RETRIEVE = 2'd1;
   localparam logic [1:0] KIND_ADD      = 2'd2;
   localparam logic [1:0] KIND_DROP     = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOSPACE   = 2'd1;
   localparam logic [1:0] ST_BADHANDLE = 2'd2;
   localparam logic [1:0] ST_ZEROSIZE  = 2'd3;

   typedef struct packed {
      logic [15:0] handle;
      logic [15:0] start;
      logic [15:0] size;
      logic [15:0] count;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ACT,
      S_SHIFT,
      S_COMPACT,
      S_ALLOC
   } state_type;

endpackage

@@ rtl/refcount_handle_allocator_compacting.sv @@
// insert allocates directly, or compacts the pool first when free offset plus size reaches the pool size
// retrieve, add, drop: scan the table for the handle (one entry read per cycle)
// a drop that frees an entry adds a shift pass over the later entries
// one item at a time; busy is high while an item is in work, results cannot be stalled
// reset: synchronous, clears counters, offset, handle and buffer; the table is not cleared
module refcount_handle_allocator_compacting
   import rhac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_size,
   input  logic [15:0] req_handle,
   output logic        rsp_valid,
   output logic [15:0] rsp_new_handle,
   output logic        rsp_buffer_select,
   output logic [15:0] rsp_start_offset,
   output logic [1:0]  rsp_status
);

   localparam logic [16:0] POOL_LIM = 17'(POOL_BYTES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBJECTS);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [15:0] free_ff, free_in;
   logic [15:0] last_ff, last_in;
   logic buf_ff, buf_in;
   logic [1:0] kind_ff, kind_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] hnd_ff, hnd_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic dv_ff, dv_in;
   logic [CNT_W-1:0] didx_ff, didx_in;
   logic [15:0] off_ff, off_in;
   entry_type ent_ff, ent_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_nh_ff, rsp_nh_in;
   logic rsp_buf_ff, rsp_buf_in;
   logic [15:0] rsp_start_ff, rsp_start_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic [16:0] sum;
   logic [15:0] cnt_dec;
   logic [CNT_W-1:0] didx_m1;

   rhac_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_OBJECTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      live_in = live_ff;
      free_in = free_ff;
      last_in = last_ff;
      buf_in = buf_ff;
      kind_in = kind_ff;
      size_in = size_ff;
      hnd_in = hnd_ff;
      issue_in = issue_ff;
      dv_in = 1'b0;
      didx_in = issue_ff;
      off_in = off_ff;
      ent_in = ent_ff;
      idx_in = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_nh_in = 16'd0;
      rsp_buf_in = buf_ff;
      rsp_start_in = 16'd0;
      rsp_status_in = ST_OK;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = ent_ff;
      rd_en = 1'b0;
      rd_addr = issue_ff[IDX_W-1:0];
      sum = 17'(free_ff) + 17'(size_ff);
      cnt_dec = ent_ff.count - 16'd1;
      didx_m1 = didx_ff - CNT_W'(1);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               size_in = req_size;
               hnd_in = req_handle;
               issue_in = '0;
               off_in = 16'd0;
               if (req_kind == KIND_INSERT) begin
                  if (req_size == 16'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = ST_ZEROSIZE;
                  end else if ((17'(free_ff) + 17'(req_size)) >= POOL_LIM) begin
                     state_in = S_COMPACT;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end else if (req_handle == 16'd0 || req_handle > last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ST_BADHANDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_en = issue_ff < live_ff;
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            dv_in = rd_en;
            if (dv_ff && rd_data.handle == hnd_ff) begin
               ent_in = rd_data;
               idx_in = didx_ff[IDX_W-1:0];
               dv_in = 1'b0;
               state_in = S_ACT;
            end else if (!rd_en && !dv_ff) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_BADHANDLE;
               state_in = S_IDLE;
            end
         end
         S_ACT: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            case (kind_ff)
               KIND_RETRIEVE: begin
                  rsp_start_in = ent_ff.start;
               end
               KIND_ADD: begin
                  wr_en = 1'b1;
                  wr_data = ent_ff;
                  if (ent_ff.count != 16'hFFFF) begin
                     wr_data.count = ent_ff.count + 16'd1;
                  end
               end
               default: begin
                  if (ent_ff.count > 16'd1) begin
                     wr_en = 1'b1;
                     wr_data = ent_ff;
                     wr_data.count = cnt_dec;
                  end else begin
                     rsp_valid_in = 1'b0;
                     issue_in = CNT_W'(idx_ff) + CNT_W'(1);
                     state_in = S_SHIFT;
                  end
               end
            endcase
         end
         S_SHIFT: begin
            rd_en = issue_ff < live_ff;
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            dv_in = rd_en;
            if (dv_ff) begin
               wr_en = 1'b1;
               wr_addr = didx_m1[IDX_W-1:0];
               wr_data = rd_data;
            end
            if (!rd_en && !dv_ff) begin
               live_in = live_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_COMPACT: begin
            rd_en = issue_ff < live_ff;
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            dv_in = rd_en;
            if (dv_ff) begin
               wr_en = 1'b1;
               wr_addr = didx_ff[IDX_W-1:0];
               wr_data = rd_data;
               wr_data.start = off_ff;
               off_in = off_ff + rd_data.size;
            end
            if (!rd_en && !dv_ff) begin
               free_in = off_ff;
               buf_in = ~buf_ff;
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (sum >= POOL_LIM || live_ff >= MAX_CNT || last_ff == 16'hFFFF) begin
               rsp_status_in = ST_NOSPACE;
            end else begin
               wr_en = 1'b1;
               wr_addr = live_ff[IDX_W-1:0];
               wr_data.handle = last_ff + 16'd1;
               wr_data.start = free_ff;
               wr_data.size = size_ff;
               wr_data.count = 16'd1;
               live_in = live_ff + CNT_W'(1);
               last_in = last_ff + 16'd1;
               free_in = sum[15:0];
               rsp_nh_in = last_ff + 16'd1;
               rsp_start_in = free_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_buf_in = buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff <= '0;
         free_ff <= 16'd0;
         last_ff <= 16'd0;
         buf_ff <= 1'b0;
         dv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff <= live_in;
         free_ff <= free_in;
         last_ff <= last_in;
         buf_ff <= buf_in;
         dv_ff <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      size_ff <= size_in;
      hnd_ff <= hnd_in;
      issue_ff <= issue_in;
      didx_ff <= didx_in;
      off_ff <= off_in;
      ent_ff <= ent_in;
      idx_ff <= idx_in;
      rsp_nh_ff <= rsp_nh_in;
      rsp_buf_ff <= rsp_buf_in;
      rsp_start_ff <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_handle = rsp_nh_ff;
   assign rsp_buffer_select = rsp_buf_ff;
   assign rsp_start_offset = rsp_start_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ rtl/rhac_ram.sv @@
module rhac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
